>>> design/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache replacement unit
// Request and response items, the opcode, and the slot update command that
// passes from the control path to the slot store.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    // One request item
    typedef struct packed {
        op_t               opcode;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] write_value;
    } req_t;

    // One response item
    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
    } rsp_t;

    // Update command applied to the selected slot
    typedef struct packed {
        logic              touch;      // hit: bump count, refresh stamp
        logic              put_value;  // hit by a put: overwrite value
        logic              fill;       // miss: load a fresh entry
        logic              grow;       // fill went into a free slot
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } slot_cmd_t;

endpackage

>>> design/lfu_lookup.sv
// ----------------------------------------------------------------------------
// lfu_lookup: associative key match
// Compares the request key against every valid slot, returns the one-hot hit
// vector with the stored value, and the one-hot lowest free slot.
// ----------------------------------------------------------------------------
module lfu_lookup #(
    parameter int ENTRIES = 16
) (
    input  logic [lfu_pkg::KEY_W-1:0]  key,
    input  logic [ENTRIES-1:0]         valid,
    input  logic [lfu_pkg::KEY_W-1:0]  keys   [ENTRIES],
    input  logic [lfu_pkg::DATA_W-1:0] values [ENTRIES],
    output logic [ENTRIES-1:0]         hit_vec,
    output logic [lfu_pkg::DATA_W-1:0] hit_value,
    output logic [ENTRIES-1:0]         free_vec
);

    logic [ENTRIES-1:0] empty;

    // Match every slot in parallel
    always_comb
    begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid[i] && (keys[i] == key);
            hit_value  = hit_value | ({lfu_pkg::DATA_W{hit_vec[i]}} & values[i]);
        end
    end

    // Isolate the lowest empty slot
    assign empty    = ~valid;
    assign free_vec = empty & (~empty + ENTRIES'(1));

endmodule

>>> design/lfu_victim.sv
// ----------------------------------------------------------------------------
// lfu_victim: least-frequently-used victim search
// Binary compare tree over {use count, stamp}; the lowest pair among valid
// slots wins, the left branch on a tie. Output is one-hot.
// ----------------------------------------------------------------------------
module lfu_victim #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic [ENTRIES-1:0]          valid,
    input  logic [COUNT_BITS-1:0]       counts [ENTRIES],
    input  logic [lfu_pkg::STAMP_W-1:0] stamps [ENTRIES],
    output logic [ENTRIES-1:0]          victim_vec
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LVL   = $clog2(ENTRIES);
    localparam int LEAFS = 1 << LVL;
    localparam int NODES = 2 * LEAFS - 1;
    localparam int RK_W  = COUNT_BITS + lfu_pkg::STAMP_W;

    logic [NODES-1:0] nv;
    logic [RK_W-1:0]  nk [NODES];
    logic [IDX_W-1:0] ni [NODES];

    // Load leaves, pad unused ones as empty
    for (genvar g = 0; g < LEAFS; g++)
    begin : g_leaf
        if (g < ENTRIES)
        begin : g_used
            assign nv[LEAFS-1+g] = valid[g];
            assign nk[LEAFS-1+g] = {counts[g], stamps[g]};
            assign ni[LEAFS-1+g] = IDX_W'(g);
        end
        else
        begin : g_pad
            assign nv[LEAFS-1+g] = 1'b0;
            assign nk[LEAFS-1+g] = '0;
            assign ni[LEAFS-1+g] = '0;
        end
    end

    // Reduce pairs toward the root
    for (genvar g = 0; g < LEAFS - 1; g++)
    begin : g_node
        logic take_left;
        assign take_left = nv[2*g+1] && (!nv[2*g+2] || (nk[2*g+1] <= nk[2*g+2]));
        assign nv[g] = nv[2*g+1] | nv[2*g+2];
        assign nk[g] = take_left ? nk[2*g+1] : nk[2*g+2];
        assign ni[g] = take_left ? ni[2*g+1] : ni[2*g+2];
    end

    // Decode the winner
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            victim_vec[i] = nv[0] && (ni[0] == IDX_W'(i));
        end
    end

endmodule

>>> design/lfu_store.sv
// ----------------------------------------------------------------------------
// lfu_store: slot storage and update
// Holds valid bits, keys, values, use counts and stamps for every slot, the
// access clock and the occupancy count. Applies one command to the selected
// slot per cycle.
// ----------------------------------------------------------------------------
module lfu_store #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfu_pkg::slot_cmd_t          cmd,
    input  logic [ENTRIES-1:0]          sel,
    output logic [ENTRIES-1:0]          valid,
    output logic [lfu_pkg::KEY_W-1:0]   keys   [ENTRIES],
    output logic [lfu_pkg::DATA_W-1:0]  values [ENTRIES],
    output logic [COUNT_BITS-1:0]       counts [ENTRIES],
    output logic [lfu_pkg::STAMP_W-1:0] stamps [ENTRIES],
    output logic [$clog2(ENTRIES+1)-1:0] used
);

    localparam int USED_W = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0]          valid_reg;
    logic [USED_W-1:0]           used_reg;
    logic [lfu_pkg::STAMP_W-1:0] clock_reg;
    logic [lfu_pkg::KEY_W-1:0]   key_reg   [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  value_reg [ENTRIES];
    logic [COUNT_BITS-1:0]       count_reg [ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0] stamp_reg [ENTRIES];

    // Control state: valid bits, occupancy, access clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
            clock_reg <= '0;
        end
        else
        begin
            if (cmd.fill)
            begin
                valid_reg <= valid_reg | sel;
            end
            if (cmd.grow)
            begin
                used_reg <= used_reg + USED_W'(1);
            end
            if (cmd.touch || cmd.fill)
            begin
                clock_reg <= clock_reg + lfu_pkg::STAMP_W'(1);
            end
        end
    end

    // Slot payload: fill or touch the selected slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (sel[i] && cmd.fill)
            begin
                key_reg[i]   <= cmd.key;
                value_reg[i] <= cmd.value;
                count_reg[i] <= COUNT_BITS'(1);
                stamp_reg[i] <= clock_reg;
            end
            else if (sel[i] && cmd.touch)
            begin
                if (count_reg[i] != {COUNT_BITS{1'b1}})
                begin
                    count_reg[i] <= count_reg[i] + COUNT_BITS'(1);
                end
                stamp_reg[i] <= clock_reg;
                if (cmd.put_value)
                begin
                    value_reg[i] <= cmd.value;
                end
            end
        end
    end

    assign valid  = valid_reg;
    assign keys   = key_reg;
    assign values = value_reg;
    assign counts = count_reg;
    assign stamps = stamp_reg;
    assign used   = used_reg;

endmodule

>>> design/lfu_cache_replacement_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_replacement_unit: LFU key/value cache with LRU tie-break
// Fully associative get/put store. Hits bump a saturating use count and
// refresh a recency stamp; a put miss fills a free slot or evicts the entry
// with the lowest count, oldest stamp first.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------
//  request  | in        | req_valid / req_ready  | req (opcode, key, write_value)
//  response | out       | rsp_valid / rsp_ready  | rsp (hit, read_value, evicted)
//  config   | in        | cfg_write              | cfg_data (capacity)
//
//  One item per cycle sustained while responses are taken; an item's
//  response passes the request register, then the response register.
//  Match, victim tree and slot update run combinationally between the
//  two registers, so each item sees the state left by the one before it.
//  A stalled response holds its register; the request register keeps taking
//  an item only once its own item moves on.
//  Reset clears valid bits, occupancy, access clock and both register valids;
//  capacity resets to 16. No clearing pass.
// ----------------------------------------------------------------------------
module lfu_cache_replacement_unit #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  lfu_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output lfu_pkg::rsp_t             rsp,
    input  logic                      cfg_write,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (USED_W > lfu_pkg::CAP_W) ? USED_W : lfu_pkg::CAP_W;

    logic [lfu_pkg::CAP_W-1:0]   cap_reg;
    logic                        in_valid_reg;
    lfu_pkg::req_t               in_item_reg;
    logic                        rsp_valid_reg;
    lfu_pkg::rsp_t               rsp_item_reg;
    lfu_pkg::rsp_t               rsp_item_next;

    logic                        advance;
    logic                        is_get;
    logic                        put_do;
    logic                        hit;
    logic                        full;
    logic                        fill;
    lfu_pkg::slot_cmd_t          cmd;
    logic [ENTRIES-1:0]          sel;

    logic [ENTRIES-1:0]          valid;
    logic [lfu_pkg::KEY_W-1:0]   keys   [ENTRIES];
    logic [lfu_pkg::DATA_W-1:0]  values [ENTRIES];
    logic [COUNT_BITS-1:0]       counts [ENTRIES];
    logic [lfu_pkg::STAMP_W-1:0] stamps [ENTRIES];
    logic [USED_W-1:0]           used;
    logic [ENTRIES-1:0]          hit_vec;
    logic [lfu_pkg::DATA_W-1:0]  hit_value;
    logic [ENTRIES-1:0]          free_vec;
    logic [ENTRIES-1:0]          victim_vec;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lfu_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Advance when the response register is free or being drained
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_item_reg <= req;
        end
    end

    lfu_lookup #(
        .ENTRIES (ENTRIES)
    ) u_lookup (
        .key       (in_item_reg.key),
        .valid     (valid),
        .keys      (keys),
        .values    (values),
        .hit_vec   (hit_vec),
        .hit_value (hit_value),
        .free_vec  (free_vec)
    );

    lfu_victim #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_victim (
        .valid      (valid),
        .counts     (counts),
        .stamps     (stamps),
        .victim_vec (victim_vec)
    );

    // Decide the action for the held item
    always_comb
    begin
        is_get = (in_item_reg.opcode == lfu_pkg::OP_GET);
        put_do = (in_item_reg.opcode == lfu_pkg::OP_PUT) && (cap_reg != '0);
        hit    = (|hit_vec) && (is_get || put_do);
        full   = (CMP_W'(used) >= CMP_W'(cap_reg)) || (used == USED_W'(ENTRIES));
        fill   = put_do && !(|hit_vec);

        cmd.touch     = advance && hit;
        cmd.put_value = put_do;
        cmd.fill      = advance && fill;
        cmd.grow      = advance && fill && !full;
        cmd.key       = in_item_reg.key;
        cmd.value     = in_item_reg.write_value;

        if (|hit_vec)
        begin
            sel = hit_vec;
        end
        else if (full)
        begin
            sel = victim_vec;
        end
        else
        begin
            sel = free_vec;
        end

        rsp_item_next.hit        = hit;
        rsp_item_next.read_value = (is_get && hit) ? hit_value : '0;
        rsp_item_next.evicted    = fill && full;
    end

    lfu_store #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sel    (sel),
        .valid  (valid),
        .keys   (keys),
        .values (values),
        .counts (counts),
        .stamps (stamps),
        .used   (used)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    // A key lives in at most one slot
    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(hit_vec))
        else $error("key matches more than one slot");

    // Occupancy count tracks the valid bits
    a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid) == used)
        else $error("occupancy count out of step with valid bits");

    // A put never both hits and evicts
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_item_reg.hit && rsp_item_reg.evicted))
        else $error("response flags hit and eviction together");

    // Eviction only happens into a full table
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill && !cmd.grow) |-> (used != '0) && (|(sel & valid)))
        else $error("eviction selected an empty slot");

endmodule

>>> tb/sv/tb_lfu_cache_replacement_unit.sv
// ----------------------------------------------------------------------------
// tb_lfu_cache_replacement_unit: self-checking bench for the LFU cache unit
// Runs a short table of directed get/put items, then phased random traffic
// under several capacity settings. Each accepted request updates a local
// LFU/LRU cache image that yields the response the unit must return, and
// each accepted response is compared field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module tb_lfu_cache_replacement_unit;

    localparam int SLOTS         = 16;
    localparam int CNT_W         = 16;
    localparam int PHASE_ITEMS   = 60;
    localparam int PHASES        = 10;
    localparam int POOL_SIZE     = 24;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 100;
    localparam int HOLD_AT_RSP   = 250;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // One row of the directed table
    typedef struct {
        bit                        set_cap;
        logic [lfu_pkg::CAP_W-1:0] cap;
        lfu_pkg::req_t             req;
        bit                        literal;
        lfu_pkg::rsp_t             rsp;
    } step_t;

    logic                      clk;
    logic                      rst_n;
    logic                      req_valid;
    logic                      req_ready;
    lfu_pkg::req_t             req;
    logic                      rsp_valid;
    logic                      rsp_ready;
    lfu_pkg::rsp_t             rsp;
    logic                      cfg_write;
    logic [lfu_pkg::CAP_W-1:0] cfg_data;

    // Local image of the cache
    logic                        cache_valid [SLOTS];
    logic [lfu_pkg::KEY_W-1:0]   cache_key   [SLOTS];
    logic [lfu_pkg::DATA_W-1:0]  cache_value [SLOTS];
    logic [CNT_W-1:0]            cache_count [SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] cache_stamp [SLOTS];
    logic [lfu_pkg::STAMP_W-1:0] cache_clock;
    logic [lfu_pkg::CAP_W-1:0]   cache_capacity;

    lfu_pkg::rsp_t             rsp_owed [$];
    logic [lfu_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                        mismatches;
    int                        rsp_taken;
    bit                        calm_phase;

    lfu_cache_replacement_unit #(
        .ENTRIES    (SLOTS),
        .COUNT_BITS (CNT_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("tb_lfu_cache_replacement_unit failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Raise the use count (saturating) and refresh the recency stamp
    function automatic void bump_slot(input int s);
        if (cache_count[s] != CNT_MAX)
            cache_count[s] = cache_count[s] + 1'b1;
        cache_stamp[s] = cache_clock;
        cache_clock    = cache_clock + 1'b1;
    endfunction

    // Apply one request to the cache image and return its response
    function automatic lfu_pkg::rsp_t apply_request(input lfu_pkg::req_t r);
        lfu_pkg::rsp_t o;
        int            s;
        int            used;
        int            eff_cap;
        o       = '0;
        s       = -1;
        used    = 0;
        eff_cap = (int'(cache_capacity) > SLOTS) ? SLOTS : int'(cache_capacity);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (s < 0 && cache_valid[i] && cache_key[i] == r.key)
                s = i;
            if (cache_valid[i])
                used++;
        end
        if (r.opcode == lfu_pkg::OP_GET)
        begin
            if (s >= 0)
            begin
                o.hit        = 1'b1;
                o.read_value = cache_value[s];
                bump_slot(s);
            end
        end
        else if (eff_cap != 0)
        begin
            if (s >= 0)
            begin
                o.hit          = 1'b1;
                cache_value[s] = r.write_value;
                bump_slot(s);
            end
            else
            begin
                if (used >= eff_cap)
                begin
                    // Evict lowest count, oldest stamp, lowest index
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!cache_valid[i])
                            continue;
                        if (s < 0 || cache_count[i] < cache_count[s] ||
                            (cache_count[i] == cache_count[s] &&
                             cache_stamp[i] < cache_stamp[s]))
                            s = i;
                    end
                    o.evicted = 1'b1;
                end
                else
                begin
                    // Take the lowest free slot
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!cache_valid[i])
                            s = i;
                end
                cache_valid[s] = 1'b1;
                cache_key[s]   = r.key;
                cache_value[s] = r.write_value;
                cache_count[s] = CNT_W'(1);
                cache_stamp[s] = cache_clock;
                cache_clock    = cache_clock + 1'b1;
            end
        end
        return o;
    endfunction

    function automatic step_t row(input bit set_cap,
                                  input logic [lfu_pkg::CAP_W-1:0] cap,
                                  input lfu_pkg::op_t op,
                                  input logic [lfu_pkg::KEY_W-1:0] k,
                                  input logic [lfu_pkg::DATA_W-1:0] v,
                                  input bit literal,
                                  input logic h,
                                  input logic [lfu_pkg::DATA_W-1:0] rd,
                                  input logic ev);
        step_t t;
        t.set_cap           = set_cap;
        t.cap               = cap;
        t.req.opcode        = op;
        t.req.key           = k;
        t.req.write_value   = v;
        t.literal           = literal;
        t.rsp.hit           = h;
        t.rsp.read_value    = rd;
        t.rsp.evicted       = ev;
        return t;
    endfunction

    function automatic lfu_pkg::req_t random_request(input int span);
        lfu_pkg::req_t r;
        int            pick;
        pick          = $urandom_range(0, 99);
        r.opcode      = lfu_pkg::op_t'($urandom_range(0, 1));
        r.write_value = $urandom;
        if (pick < 82)
            r.key = key_pool[$urandom_range(0, span)];
        else if (pick < 87)
            r.key = '0;
        else if (pick < 92)
            r.key = '1;
        else
            r.key = $urandom;
        return r;
    endfunction

    // Offer one item, wait for its acceptance, and record its response.
    // Entered and left at a falling edge.
    task automatic send_item(input lfu_pkg::req_t r, input bit literal,
                             input lfu_pkg::rsp_t fixed);
        int            gap;
        lfu_pkg::rsp_t due;
        gap = calm_phase ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        due = apply_request(r);
        rsp_owed.push_back(literal ? fixed : due);
        @(negedge clk);
    endtask

    // Drain the unit, then write the capacity register
    task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] cap);
        req_valid <= 1'b0;
        while (rsp_owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= cap;
        @(negedge clk);
        cfg_write      <= 1'b0;
        cache_capacity  = cap;
    endtask

    // Response side: random stalls, one long hold, check every item taken
    initial
    begin
        int            stall;
        lfu_pkg::rsp_t want;
        rsp_ready = 1'b0;
        rsp_taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm_phase ? 0 : $urandom_range(0, 4);
            if (rsp_taken == HOLD_AT_RSP)
                stall = HOLD_CYCLES;
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            rsp_taken++;
            if (rsp_owed.size() == 0)
                report_mismatch("response with none outstanding");
            else
            begin
                want = rsp_owed.pop_front();
                if (rsp.hit !== want.hit)
                    report_mismatch($sformatf("hit got %0b want %0b",
                                              rsp.hit, want.hit));
                if (rsp.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value got %08h want %08h",
                                              rsp.read_value, want.read_value));
                if (rsp.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted got %0b want %0b",
                                              rsp.evicted, want.evicted));
            end
            @(negedge clk);
        end
    end

    // Reset, directed table, random phases, final verdict
    initial
    begin
        step_t                     plan [$];
        logic [lfu_pkg::CAP_W-1:0] phase_cap [PHASES];
        int                        span;
        lfu_pkg::rsp_t             none;
        none           = '0;
        mismatches     = 0;
        calm_phase     = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        cfg_write      = 1'b0;
        cfg_data       = lfu_pkg::CAP_RESET;
        cache_clock    = '0;
        cache_capacity = lfu_pkg::CAP_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_count[i] = '0;
            cache_stamp[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // Empty table, key and value extremes, get and put hits
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_GET, '0, '0, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_GET, '1, '1, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_PUT, '0, '1, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_PUT, '1, '0, 1'b1, 1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_GET, '0, '0, 1'b1, 1'b1, '1, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_GET, '1, '0, 1'b1, 1'b1, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_PUT, '0, 32'h5A5A_A5A5, 1'b1,
                           1'b1, '0, 1'b0));
        // Fill the table, then evict on a tie of counts
        for (int k = 1; k <= 14; k++)
            plan.push_back(row(1'b0, '0, lfu_pkg::OP_PUT, 32'(k), 32'h1000 + 32'(k),
                               1'b0, 1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_PUT, 32'h100, 32'hCAFE_0100, 1'b0,
                           1'b0, '0, 1'b0));
        // Zero capacity: puts dropped, gets still look up
        plan.push_back(row(1'b1, 5'd0, lfu_pkg::OP_PUT, 32'h200, 32'h0200, 1'b1,
                           1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_GET, '0, '0, 1'b0, 1'b0, '0, 1'b0));
        plan.push_back(row(1'b0, '0, lfu_pkg::OP_GET, 32'h200, '0, 1'b1,
                           1'b0, '0, 1'b0));
        // Capacity above the slot count, then below occupancy
        plan.push_back(row(1'b1, 5'd31, lfu_pkg::OP_PUT, 32'h300, 32'h0300, 1'b0,
                           1'b0, '0, 1'b0));
        plan.push_back(row(1'b1, 5'd1, lfu_pkg::OP_PUT, 32'h400, 32'h0400, 1'b0,
                           1'b0, '0, 1'b0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].set_cap)
                write_capacity(plan[i].cap);
            send_item(plan[i].req, plan[i].literal, plan[i].rsp);
        end

        // Random phases over a spread of capacities
        phase_cap[0] = 5'd16;
        phase_cap[1] = 5'd1;
        phase_cap[2] = 5'd2;
        phase_cap[3] = 5'd31;
        phase_cap[4] = 5'd0;
        phase_cap[5] = 5'd8;
        phase_cap[6] = 5'd4;
        phase_cap[7] = lfu_pkg::CAP_W'($urandom_range(0, 31));
        phase_cap[8] = lfu_pkg::CAP_W'($urandom_range(0, 31));
        phase_cap[9] = 5'd16;
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(phase_cap[p]);
            calm_phase = (p % 4 == 3);
            span       = $urandom_range(2, POOL_SIZE - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_request(span), 1'b0, none);
        end
        calm_phase = 1'b0;
        req_valid <= 1'b0;

        // Wait out the last responses
        while (rsp_owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_lfu_cache_replacement_unit passed");
        else
            $display("tb_lfu_cache_replacement_unit failed");
        $finish;
    end

endmodule

>>> files.f
design/lfu_pkg.sv
design/lfu_lookup.sv
design/lfu_victim.sv
design/lfu_store.sv
design/lfu_cache_replacement_unit.sv
tb/sv/tb_lfu_cache_replacement_unit.sv
